// ===== rtl/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Line-follow PD steering package
// Shared types and constants for the steering datapath and its top level.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int DriveBits = 15;
  localparam int GainBits  = 8;

  typedef enum logic [2:0] {
    CLS_WHITE = 3'd0,
    CLS_BLACK = 3'd1,
    CLS_LEFT  = 3'd2,
    CLS_RIGHT = 3'd3,
    CLS_NONE  = 3'd4
  } class_e;

  localparam logic [1:0] REG_CRUISE_LEFT  = 2'd0;
  localparam logic [1:0] REG_CRUISE_RIGHT = 2'd1;
  localparam logic [1:0] REG_ERROR_GAIN   = 2'd2;

  localparam logic [DriveBits-1:0] CRUISE_LEFT_RST  = 15'd16000;
  localparam logic [DriveBits-1:0] CRUISE_RIGHT_RST = 15'd15000;
  localparam logic [GainBits-1:0]  ERROR_GAIN_RST   = 8'd100;

  localparam int TURN_L_RIGHT = 12000;
  localparam int TURN_L_LEFT  = 8000;
  localparam int TURN_R_RIGHT = 14000;
  localparam int TURN_R_LEFT  = 6000;
  localparam int BLACK_RIGHT  = 12000;
  localparam int BLACK_LEFT   = 6000;

  typedef struct packed {
    logic [DriveBits-1:0] cruise_left;
    logic [DriveBits-1:0] cruise_right;
    logic [GainBits-1:0]  error_gain;
  } cfg_t;

endpackage

// ===== rtl/lfpd_core.sv =====
// ----------------------------------------------------------------------------
// Line-follow PD steering datapath
// Computes the drive levels and the next tracking state for one item.
// ----------------------------------------------------------------------------
module lfpd_core #(
  parameter int SENSOR_BITS = 10,
  parameter int DRIVE_MAX   = 32000
) (
  input  logic                              ready_req_i,
  input  logic [1:0]                        line_class_i,
  input  logic [SENSOR_BITS-1:0]            left_sensor_i,
  input  logic [SENSOR_BITS-1:0]            right_sensor_i,
  input  lfpd_pkg::cfg_t                    cfg_i,
  input  lfpd_pkg::class_e                  last_class_i,
  input  logic signed [SENSOR_BITS:0]       last_error_i,
  output lfpd_pkg::class_e                  last_class_o,
  output logic signed [SENSOR_BITS:0]       last_error_o,
  output logic [lfpd_pkg::DriveBits-1:0]    right_drive_o,
  output logic [lfpd_pkg::DriveBits-1:0]    left_drive_o
);

  localparam int EW = SENSOR_BITS + 1;
  localparam int W  = SENSOR_BITS + 13;

  logic signed [EW-1:0] err;
  logic signed [W-1:0]  err_w;
  logic signed [W-1:0]  last_w;
  logic signed [W-1:0]  sum_w;
  logic signed [W-1:0]  gain_w;
  logic signed [W-1:0]  prod_w;
  logic signed [W-1:0]  right_raw;
  logic signed [W-1:0]  left_raw;
  lfpd_pkg::class_e     cls;

  function automatic logic [lfpd_pkg::DriveBits-1:0] sat_drive(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > W'(DRIVE_MAX)) begin
      r = W'(DRIVE_MAX);
    end else begin
      r = v;
    end
    return r[lfpd_pkg::DriveBits-1:0];
  endfunction

  assign cls    = lfpd_pkg::class_e'({1'b0, line_class_i});
  assign err    = $signed({1'b0, left_sensor_i}) - $signed({1'b0, right_sensor_i});
  assign err_w  = {{(W-EW){err[EW-1]}}, err};
  assign last_w = {{(W-EW){last_error_i[EW-1]}}, last_error_i};
  assign sum_w  = (err_w <<< 1) - last_w;
  assign gain_w = $signed({{(W-lfpd_pkg::GainBits){1'b0}}, cfg_i.error_gain});
  assign prod_w = sum_w * gain_w;

  always_comb begin
    right_raw    = '0;
    left_raw     = '0;
    last_class_o = last_class_i;
    last_error_o = last_error_i;
    if (ready_req_i) begin
      last_class_o = cls;
      case (cls)
        lfpd_pkg::CLS_WHITE: begin
          if (last_class_i == lfpd_pkg::CLS_LEFT) begin
            right_raw    = W'(lfpd_pkg::TURN_L_RIGHT);
            left_raw     = W'(lfpd_pkg::TURN_L_LEFT);
            last_class_o = lfpd_pkg::CLS_LEFT;
          end else if (last_class_i == lfpd_pkg::CLS_RIGHT) begin
            right_raw    = W'(lfpd_pkg::TURN_R_RIGHT);
            left_raw     = W'(lfpd_pkg::TURN_R_LEFT);
            last_class_o = lfpd_pkg::CLS_RIGHT;
          end
        end
        lfpd_pkg::CLS_BLACK: begin
          right_raw = W'(lfpd_pkg::BLACK_RIGHT);
          left_raw  = W'(lfpd_pkg::BLACK_LEFT);
        end
        default: begin
          right_raw    = $signed({{(W-lfpd_pkg::DriveBits){1'b0}}, cfg_i.cruise_right}) + prod_w;
          left_raw     = $signed({{(W-lfpd_pkg::DriveBits){1'b0}}, cfg_i.cruise_left}) - prod_w;
          last_error_o = err;
        end
      endcase
    end
  end

  assign right_drive_o = sat_drive(right_raw);
  assign left_drive_o  = sat_drive(left_raw);

endmodule

// ===== rtl/line_follow_pd_steering_unit.sv =====
// ----------------------------------------------------------------------------
// Line-follow PD steering unit
// One item of sensor data in, one item of right and left drive levels out.
//
// The input channel carries the ready flag, the line class and the two
// reflectance samples; the output channel carries the right and left drive
// levels. Both channels use valid and ready. Each item is computed in the
// cycle it is accepted and appears on the output in the next cycle. The
// unit accepts one item per cycle; the output register is the only stage,
// and a new item is taken whenever the register is empty or its item is
// taken in the same cycle. When the receiver stalls, the result holds and
// the input ready drops until it is taken. Reset empties the output
// register, restores the register defaults, forgets the remembered line
// class and clears the previous error. Configuration writes take effect at
// the next clock edge and are meant for idle periods.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_unit #(
  parameter int SENSOR_BITS = 10,
  parameter int DRIVE_MAX   = 32000
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [lfpd_pkg::DriveBits-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           ready_req_i,
  input  logic [1:0]                     line_class_i,
  input  logic [SENSOR_BITS-1:0]         left_sensor_i,
  input  logic [SENSOR_BITS-1:0]         right_sensor_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lfpd_pkg::DriveBits-1:0] right_drive_o,
  output logic [lfpd_pkg::DriveBits-1:0] left_drive_o
);

  lfpd_pkg::cfg_t                  cfg_q;
  lfpd_pkg::class_e                last_class_q;
  lfpd_pkg::class_e                last_class_d;
  logic signed [SENSOR_BITS:0]     last_error_q;
  logic signed [SENSOR_BITS:0]     last_error_d;
  logic                            out_valid_q;
  logic [lfpd_pkg::DriveBits-1:0]  right_drive_q;
  logic [lfpd_pkg::DriveBits-1:0]  left_drive_q;
  logic [lfpd_pkg::DriveBits-1:0]  right_drive_d;
  logic [lfpd_pkg::DriveBits-1:0]  left_drive_d;
  logic                            accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  lfpd_core #(
    .SENSOR_BITS(SENSOR_BITS),
    .DRIVE_MAX  (DRIVE_MAX)
  ) u_core (
    .ready_req_i   (ready_req_i),
    .line_class_i  (line_class_i),
    .left_sensor_i (left_sensor_i),
    .right_sensor_i(right_sensor_i),
    .cfg_i         (cfg_q),
    .last_class_i  (last_class_q),
    .last_error_i  (last_error_q),
    .last_class_o  (last_class_d),
    .last_error_o  (last_error_d),
    .right_drive_o (right_drive_d),
    .left_drive_o  (left_drive_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_left  <= lfpd_pkg::CRUISE_LEFT_RST;
      cfg_q.cruise_right <= lfpd_pkg::CRUISE_RIGHT_RST;
      cfg_q.error_gain   <= lfpd_pkg::ERROR_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lfpd_pkg::REG_CRUISE_LEFT:  cfg_q.cruise_left  <= cfg_wdata_i;
        lfpd_pkg::REG_CRUISE_RIGHT: cfg_q.cruise_right <= cfg_wdata_i;
        lfpd_pkg::REG_ERROR_GAIN: begin
          cfg_q.error_gain <= cfg_wdata_i[lfpd_pkg::GainBits-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_class_q <= lfpd_pkg::CLS_NONE;
      last_error_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        last_class_q <= last_class_d;
        last_error_q <= last_error_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      right_drive_q <= right_drive_d;
      left_drive_q  <= left_drive_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign right_drive_o = right_drive_q;
  assign left_drive_o  = left_drive_q;

endmodule

// ===== verif/line_follow_pd_steering_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-follow PD steering unit testbench
// Drives sensor items through the steering unit under varied handshake
// pressure and register settings. A cycle-free predictor computes the
// right and left drive levels of every accepted item, and a monitor
// compares each result item with the oldest pending prediction.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_unit_test;

  localparam int SensorBits = 10;
  localparam int DriveMax   = 32000;
  localparam int DriveBits  = lfpd_pkg::DriveBits;
  localparam int GainBits   = lfpd_pkg::GainBits;
  localparam int ItemsPerSet = 122;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [DriveBits-1:0] right;
    logic [DriveBits-1:0] left;
  } drive_pair_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [1:0]            cfg_index_i;
  logic [DriveBits-1:0]  cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  ready_req_i;
  logic [1:0]            line_class_i;
  logic [SensorBits-1:0] left_sensor_i;
  logic [SensorBits-1:0] right_sensor_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [DriveBits-1:0]  right_drive_o;
  logic [DriveBits-1:0]  left_drive_o;

  lfpd_pkg::cfg_t           cfg_model;
  lfpd_pkg::class_e         seen_class;
  logic signed [SensorBits:0] prev_error;
  drive_pair_t              expected_drive_q[$];
  int                       fail_count;
  int                       sent_count;
  int                       setting_count;
  int                       idle_pct;
  int                       stall_pct;

  line_follow_pd_steering_unit #(
    .SENSOR_BITS(SensorBits),
    .DRIVE_MAX  (DriveMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ready_req_i   (ready_req_i),
    .line_class_i  (line_class_i),
    .left_sensor_i (left_sensor_i),
    .right_sensor_i(right_sensor_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .right_drive_o (right_drive_o),
    .left_drive_o  (left_drive_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [DriveBits-1:0] clamp_drive(longint level);
    if (level < 0) level = 0;
    if (level > DriveMax) level = DriveMax;
    return level[DriveBits-1:0];
  endfunction

  function automatic drive_pair_t steer_predict(logic rdy, logic [1:0] cls_bits,
                                                logic [SensorBits-1:0] ls,
                                                logic [SensorBits-1:0] rs);
    lfpd_pkg::class_e cls;
    longint      err;
    longint      trim;
    longint      right_lv;
    longint      left_lv;
    drive_pair_t res;
    cls = lfpd_pkg::class_e'({1'b0, cls_bits});
    right_lv = 0;
    left_lv = 0;
    if (rdy) begin
      case (cls)
        lfpd_pkg::CLS_WHITE: begin
          if (seen_class == lfpd_pkg::CLS_LEFT) begin
            right_lv = lfpd_pkg::TURN_L_RIGHT;
            left_lv = lfpd_pkg::TURN_L_LEFT;
            cls = lfpd_pkg::CLS_LEFT;
          end else if (seen_class == lfpd_pkg::CLS_RIGHT) begin
            right_lv = lfpd_pkg::TURN_R_RIGHT;
            left_lv = lfpd_pkg::TURN_R_LEFT;
            cls = lfpd_pkg::CLS_RIGHT;
          end
        end
        lfpd_pkg::CLS_BLACK: begin
          right_lv = lfpd_pkg::BLACK_RIGHT;
          left_lv = lfpd_pkg::BLACK_LEFT;
        end
        default: begin
          err = longint'(ls) - longint'(rs);
          trim = (err + (err - longint'(prev_error))) * longint'(cfg_model.error_gain);
          prev_error = err[SensorBits:0];
          right_lv = longint'(cfg_model.cruise_right) + trim;
          left_lv = longint'(cfg_model.cruise_left) - trim;
        end
      endcase
      seen_class = cls;
    end
    res.right = clamp_drive(right_lv);
    res.left = clamp_drive(left_lv);
    return res;
  endfunction

  // Results are checked before the item accepted at the same edge is
  // predicted, and register writes land after that prediction.
  always @(posedge clk_i) begin : monitor
    drive_pair_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_drive_q.size() == 0) begin
          $error("result item with no pending prediction: right %0d left %0d",
                 right_drive_o, left_drive_o);
          fail_count++;
        end else begin
          want = expected_drive_q.pop_front();
          if (right_drive_o !== want.right) begin
            $error("right_drive mismatch: expected %0d actual %0d", want.right,
                   right_drive_o);
            fail_count++;
          end
          if (left_drive_o !== want.left) begin
            $error("left_drive mismatch: expected %0d actual %0d", want.left,
                   left_drive_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_drive_q.push_back(steer_predict(ready_req_i, line_class_i,
                                                 left_sensor_i, right_sensor_i));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          lfpd_pkg::REG_CRUISE_LEFT:  cfg_model.cruise_left = cfg_wdata_i;
          lfpd_pkg::REG_CRUISE_RIGHT: cfg_model.cruise_right = cfg_wdata_i;
          lfpd_pkg::REG_ERROR_GAIN:   cfg_model.error_gain = cfg_wdata_i[GainBits-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(logic rdy, logic [1:0] cls, logic [SensorBits-1:0] ls,
                           logic [SensorBits-1:0] rs);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ready_req_i <= rdy;
    line_class_i <= cls;
    left_sensor_i <= ls;
    right_sensor_i <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DriveBits-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [DriveBits-1:0] cl, logic [DriveBits-1:0] cr,
                           logic [DriveBits-1:0] gain_data, bit poke_unused);
    write_reg(lfpd_pkg::REG_CRUISE_LEFT, cl);
    write_reg(lfpd_pkg::REG_CRUISE_RIGHT, cr);
    write_reg(lfpd_pkg::REG_ERROR_GAIN, gain_data);
    if (poke_unused) write_reg(RegUnused, DriveBits'($urandom()));
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  task automatic test_reset_defaults();
    idle_pct = 0;
    stall_pct = 0;
    send_item(1'b0, lfpd_pkg::CLS_LEFT, 10'd1023, 10'd0);
    send_item(1'b1, lfpd_pkg::CLS_WHITE, 10'd0, 10'd0);
    send_item(1'b1, lfpd_pkg::CLS_BLACK, 10'd512, 10'd3);
    send_item(1'b1, lfpd_pkg::CLS_WHITE, 10'd7, 10'd9);
    send_item(1'b1, lfpd_pkg::CLS_LEFT, 10'd1023, 10'd0);
    send_item(1'b1, lfpd_pkg::CLS_WHITE, 10'd0, 10'd1023);
    send_item(1'b0, lfpd_pkg::CLS_WHITE, 10'd0, 10'd0);
    send_item(1'b1, lfpd_pkg::CLS_WHITE, 10'd1023, 10'd1023);
    send_item(1'b1, lfpd_pkg::CLS_RIGHT, 10'd0, 10'd1023);
    send_item(1'b1, lfpd_pkg::CLS_WHITE, 10'd100, 10'd200);
    send_item(1'b1, lfpd_pkg::CLS_WHITE, 10'd300, 10'd200);
    send_item(1'b1, lfpd_pkg::CLS_LEFT, 10'd500, 10'd500);
    send_item(1'b1, lfpd_pkg::CLS_RIGHT, 10'd510, 10'd500);
    send_item(1'b1, lfpd_pkg::CLS_LEFT, 10'd1023, 10'd1023);
    send_item(1'b1, lfpd_pkg::CLS_RIGHT, 10'd0, 10'd0);
    send_item(1'b0, lfpd_pkg::CLS_BLACK, 10'd0, 10'd0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    configure('0, '0, '0, 1'b1);
    send_item(1'b1, lfpd_pkg::CLS_LEFT, 10'd1023, 10'd0);
    send_item(1'b1, lfpd_pkg::CLS_RIGHT, 10'd0, 10'd1023);
    send_item(1'b1, lfpd_pkg::CLS_WHITE, 10'd5, 10'd5);
    wait_idle();
    configure(15'd32000, 15'h7FFF, 15'h7FFF, 1'b1);
    send_item(1'b1, lfpd_pkg::CLS_LEFT, 10'd0, 10'd0);
    send_item(1'b1, lfpd_pkg::CLS_RIGHT, 10'd3, 10'd1);
    send_item(1'b1, lfpd_pkg::CLS_LEFT, 10'd1, 10'd3);
    send_item(1'b1, lfpd_pkg::CLS_WHITE, 10'd0, 10'd0);
    send_item(1'b1, lfpd_pkg::CLS_BLACK, 10'd1023, 10'd1023);
    wait_idle();
  endtask

  function automatic logic [DriveBits-1:0] pick_cruise();
    case ($urandom_range(5))
      0: return '0;
      1: return 15'd32000;
      2: return 15'h7FFF;
      default: return DriveBits'($urandom_range(32767));
    endcase
  endfunction

  function automatic logic [DriveBits-1:0] pick_gain_data();
    case ($urandom_range(5))
      0: return DriveBits'($urandom_range(127)) << GainBits;
      1: return (DriveBits'($urandom_range(127)) << GainBits) | 15'h00FF;
      default: return DriveBits'($urandom());
    endcase
  endfunction

  task automatic test_random_tracking();
    int phase_idle[4];
    int phase_stall[4];
    int ls;
    int rs;
    phase_idle = '{0, 49, 0, 21};
    phase_stall = '{0, 0, 49, 21};
    for (int ph = 0; ph < 4; ph++) begin
      for (int set = 0; set < 4; set++) begin
        idle_pct = 0;
        stall_pct = 0;
        configure(pick_cruise(), pick_cruise(), pick_gain_data(), ($urandom_range(3) == 0));
        idle_pct = phase_idle[ph];
        stall_pct = phase_stall[ph];
        for (int n = 0; n < ItemsPerSet; n++) begin
          ls = $urandom_range(1023);
          // Near-balanced readings keep most PD steps out of saturation.
          if ($urandom_range(9) < 6) begin
            rs = ls + int'($urandom_range(60)) - 30;
            if (rs < 0) rs = 0;
            if (rs > 1023) rs = 1023;
          end else begin
            rs = $urandom_range(1023);
          end
          send_item(($urandom_range(99) < 85), 2'($urandom_range(3)), ls[SensorBits-1:0],
                    rs[SensorBits-1:0]);
        end
        wait_idle();
      end
    end
  endtask

  initial begin
    fail_count = 0;
    sent_count = 0;
    setting_count = 1;
    idle_pct = 0;
    stall_pct = 0;
    cfg_model.cruise_left = lfpd_pkg::CRUISE_LEFT_RST;
    cfg_model.cruise_right = lfpd_pkg::CRUISE_RIGHT_RST;
    cfg_model.error_gain = lfpd_pkg::ERROR_GAIN_RST;
    seen_class = lfpd_pkg::CLS_NONE;
    prev_error = '0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    ready_req_i = 1'b0;
    line_class_i = '0;
    left_sensor_i = '0;
    right_sensor_i = '0;
    out_ready_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_random_tracking();
    $display("Sent %0d sensor items across %0d register settings,", sent_count, setting_count);
    $display("with free-running, sender-idle, receiver-stall and mixed handshakes.");
    if (fail_count == 0 && expected_drive_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_drive_q.size() != 0) begin
        $error("%0d predicted result items never arrived", expected_drive_q.size());
      end
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d result items pending", expected_drive_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lfpd_pkg.sv
rtl/lfpd_core.sv
rtl/line_follow_pd_steering_unit.sv
verif/line_follow_pd_steering_unit_test.sv
